@@ rtl/tsba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsba_pkg
// Shared field widths, operation and status codes, and the command and status
// structures between the allocator's controller and datapath.
// ----------------------------------------------------------------------------
package tsba_pkg;

  localparam int OP_W        = 2;
  localparam int FRAME_LEN_W = 12;
  localparam int EXTRA_W     = 4;
  localparam int ID_W        = 8;
  localparam int CREDIT_W    = 8;
  localparam int HDR_W       = 8;
  localparam int STATUS_W    = 2;
  localparam int SLOT_OUT_W  = 4;
  localparam int TOTAL_W     = 6;
  localparam int POOL_W      = 10;
  localparam int FLIGHT_W    = 5;

  localparam int MAX_BYTES = (2 ** FRAME_LEN_W - 1) + (2 ** HDR_W - 1) + (2 ** EXTRA_W - 1);

  localparam logic [HDR_W-1:0]  HDR_RESET = 8'd16;
  localparam logic [POOL_W-1:0] POOL_MAX  = 10'd1023;

  localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
  localparam logic [OP_W-1:0] OP_CREDIT   = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_BUSY    = 2'd1;
  localparam logic [STATUS_W-1:0] STS_ILLEGAL = 2'd2;

  typedef struct packed {
    logic load;
    logic mul;
    logic fix;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic alloc_op;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/tx_slot_and_block_allocator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tx_slot_and_block_allocator_unit
// Transmit descriptor allocator: claims slots and memory blocks for frames,
// frees slots on completion and credits blocks returned by the device.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate passes through the
// reciprocal multiply and the correction step, and a complete, a credit or
// an unused code skips the correction step, before its result is registered,
// as long as the output is free; a result that still waits at the output
// holds the unit until it is taken. The next request can be taken in the
// cycle after the result is registered, also while that result still waits
// at the output. The slot table and the block pool are updated when the
// result is registered. The user must write the descriptor header size
// through the configuration port only while the unit is idle; the unit
// itself does not enforce this. The header size resets to sixteen bytes.
module tx_slot_and_block_allocator_unit #(
  parameter int SLOTS        = 16,
  parameter int BLOCK_BYTES  = 252,
  parameter int SPARE_BLOCKS = 2
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tsba_pkg::HDR_W-1:0]        cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [tsba_pkg::OP_W-1:0]         op_i,
  input  wire logic [tsba_pkg::FRAME_LEN_W-1:0]  frame_len_i,
  input  wire logic [tsba_pkg::EXTRA_W-1:0]      extra_bytes_i,
  input  wire logic [tsba_pkg::ID_W-1:0]         slot_id_i,
  input  wire logic [tsba_pkg::CREDIT_W-1:0]     credit_blocks_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [tsba_pkg::STATUS_W-1:0]          status_o,
  output logic [tsba_pkg::SLOT_OUT_W-1:0]        assigned_slot_o,
  output logic [tsba_pkg::TOTAL_W-1:0]           alloc_blocks_o,
  output logic [tsba_pkg::POOL_W-1:0]            blocks_left_o,
  output logic [tsba_pkg::FLIGHT_W-1:0]          frames_in_flight_o
);
  import tsba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tsba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tsba_dpath #(
    .SLOTS        (SLOTS),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .SPARE_BLOCKS (SPARE_BLOCKS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .op_i               (op_i),
    .frame_len_i        (frame_len_i),
    .extra_bytes_i      (extra_bytes_i),
    .slot_id_i          (slot_id_i),
    .credit_blocks_i    (credit_blocks_i),
    .status_o           (status_o),
    .assigned_slot_o    (assigned_slot_o),
    .alloc_blocks_o     (alloc_blocks_o),
    .blocks_left_o      (blocks_left_o),
    .frames_in_flight_o (frames_in_flight_o)
  );

endmodule
`default_nettype wire

@@ rtl/tsba_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsba_ctrl
// Sequencer for the allocator: accepts one request, steps the block count
// through the reciprocal multiply and correction, and commits the result.
// ----------------------------------------------------------------------------
module tsba_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire tsba_pkg::sts_t   sts_i,
  output tsba_pkg::cmd_t        cmd_o
);
  import tsba_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_EXEC = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   commit;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign commit      = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.mul    = (state_q == ST_MUL);
    cmd_o.fix    = (state_q == ST_FIX);
    cmd_o.commit = commit;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = sts_i.alloc_op ? ST_FIX : ST_EXEC;
      end
      ST_FIX: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tsba_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsba_dpath
// Datapath of the allocator: request registers, block count by reciprocal
// multiplication with one correction step, slot table, pool and result
// registers.
// ----------------------------------------------------------------------------
module tsba_dpath #(
  parameter int SLOTS        = 16,
  parameter int BLOCK_BYTES  = 252,
  parameter int SPARE_BLOCKS = 2
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tsba_pkg::cmd_t                    cmd_i,
  output tsba_pkg::sts_t                         sts_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [tsba_pkg::HDR_W-1:0]        cfg_wdata_i,
  input  wire logic [tsba_pkg::OP_W-1:0]         op_i,
  input  wire logic [tsba_pkg::FRAME_LEN_W-1:0]  frame_len_i,
  input  wire logic [tsba_pkg::EXTRA_W-1:0]      extra_bytes_i,
  input  wire logic [tsba_pkg::ID_W-1:0]         slot_id_i,
  input  wire logic [tsba_pkg::CREDIT_W-1:0]     credit_blocks_i,
  output logic [tsba_pkg::STATUS_W-1:0]          status_o,
  output logic [tsba_pkg::SLOT_OUT_W-1:0]        assigned_slot_o,
  output logic [tsba_pkg::TOTAL_W-1:0]           alloc_blocks_o,
  output logic [tsba_pkg::POOL_W-1:0]            blocks_left_o,
  output logic [tsba_pkg::FLIGHT_W-1:0]          frames_in_flight_o
);
  import tsba_pkg::*;

  localparam int XMAX  = MAX_BYTES + BLOCK_BYTES - 1;
  localparam int XW    = $clog2(XMAX + 1);
  localparam int K     = XW + 1;
  localparam int RECIP = (2 ** K) / BLOCK_BYTES;
  localparam int MW    = $clog2(RECIP + 1);
  localparam int PW    = XW + MW;
  localparam int QMAX  = XMAX / BLOCK_BYTES;
  localparam int QW    = $clog2(QMAX + 1);
  localparam int NW    = $clog2(QMAX + SPARE_BLOCKS + 1);
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);

  logic [HDR_W-1:0]    hdr_q;
  logic [OP_W-1:0]     op_q;
  logic [ID_W-1:0]     id_q;
  logic [CREDIT_W-1:0] credit_q;
  logic [XW-1:0]       x_q;
  logic [QW-1:0]       q_est_q;
  logic [NW-1:0]       need_q;

  logic [SLOTS-1:0]  busy_q, busy_d;
  logic [CW-1:0]     count_q, count_d;
  logic [POOL_W-1:0] pool_q, pool_d;

  logic [STATUS_W-1:0]   status_q, status_d;
  logic [SLOT_OUT_W-1:0] slot_q, slot_d;
  logic [TOTAL_W-1:0]    total_q, total_d;

  logic [PW-1:0]     prod;
  logic [XW:0]       qb;
  logic [XW:0]       rem;
  logic              rem_ge;
  logic [SW-1:0]     free_idx;
  logic              free_found;
  logic [POOL_W:0]   pool_sum;
  logic [POOL_W-1:0] need_ext;

  assign sts_o.alloc_op = (op_q == OP_ALLOC);

  assign prod   = PW'(x_q) * PW'(RECIP);
  assign qb     = (XW + 1)'(q_est_q * BLOCK_BYTES);
  assign rem    = (XW + 1)'(x_q) - qb;
  assign rem_ge = (rem >= (XW + 1)'(BLOCK_BYTES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= HDR_RESET;
    end else if (cfg_we_i) begin
      hdr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      id_q     <= slot_id_i;
      credit_q <= credit_blocks_i;
      x_q      <= XW'(frame_len_i) + XW'(hdr_q) + XW'(extra_bytes_i) + XW'(BLOCK_BYTES - 1);
    end
    if (cmd_i.mul) begin
      q_est_q <= QW'(prod >> K);
    end
    if (cmd_i.fix) begin
      need_q <= NW'(q_est_q) + NW'(rem_ge) + NW'(SPARE_BLOCKS);
    end
  end

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign need_ext = POOL_W'(need_q);
  assign pool_sum = (POOL_W + 1)'(pool_q) + (POOL_W + 1)'(credit_q);

  always_comb begin
    busy_d   = busy_q;
    count_d  = count_q;
    pool_d   = pool_q;
    status_d = STS_OK;
    slot_d   = '0;
    total_d  = '0;
    case (op_q)
      OP_ALLOC: begin
        if (!free_found) begin
          status_d = STS_BUSY;
        end else begin
          total_d = TOTAL_W'(need_q);
          if (need_ext <= pool_q) begin
            busy_d[free_idx] = 1'b1;
            count_d          = count_q + CW'(1);
            pool_d           = pool_q - need_ext;
            slot_d           = SLOT_OUT_W'(free_idx);
          end else begin
            status_d = STS_BUSY;
          end
        end
      end
      OP_COMPLETE: begin
        if ((id_q >= ID_W'(SLOTS)) || !busy_q[id_q[SW-1:0]]) begin
          status_d = STS_ILLEGAL;
        end else begin
          busy_d[id_q[SW-1:0]] = 1'b0;
          count_d              = count_q - CW'(1);
        end
      end
      OP_CREDIT: begin
        pool_d = (pool_sum > (POOL_W + 1)'(POOL_MAX)) ? POOL_MAX : pool_sum[POOL_W-1:0];
      end
      default: begin
        status_d = STS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      count_q <= '0;
      pool_q  <= '0;
    end else if (cmd_i.commit) begin
      busy_q  <= busy_d;
      count_q <= count_d;
      pool_q  <= pool_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      total_q  <= total_d;
    end
  end

  assign status_o           = status_q;
  assign assigned_slot_o    = slot_q;
  assign alloc_blocks_o     = total_q;
  assign blocks_left_o      = pool_q;
  assign frames_in_flight_o = FLIGHT_W'(count_q);

endmodule
`default_nettype wire
